// ===== rtl/assert_macros.svh =====
// assertion helpers for the sorted record table checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define NST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define NST_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/nst_pkg.sv =====
// ----------------------------------------------------------------------------
// nst_pkg
// Shared types and constants of the newest-n sorted record table: field
// widths, transaction structs, action and status codes, cell commands.
// ----------------------------------------------------------------------------
package nst_pkg;

    localparam int NST_DEPTH   = 256;
    localparam int TIME_W      = 40;
    localparam int GRAMS_W     = 20;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 9;
    localparam int INDEX_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 40;

    localparam logic [GRAMS_W-1:0] MIN_GRAMS_RESET  = GRAMS_W'(20000);
    localparam logic [GRAMS_W-1:0] MAX_GRAMS_RESET  = GRAMS_W'(500000);
    localparam logic [TIME_W-1:0]  TIME_LIMIT_RESET = TIME_W'(64'd4102444800);

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_GRAMS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_GRAMS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_LIMIT = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

    localparam logic [2:0] CMD_HOLD   = 3'd0;
    localparam logic [2:0] CMD_HIT    = 3'd1;
    localparam logic [2:0] CMD_PREFIX = 3'd2;
    localparam logic [2:0] CMD_SHIFT  = 3'd3;
    localparam logic [2:0] CMD_INSERT = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   new_time;
        logic [GRAMS_W-1:0]  new_grams;
        logic [TIME_W-1:0]   match_time;
        logic [GRAMS_W-1:0]  match_grams;
        logic [INDEX_W-1:0]  read_index;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic [TIME_W-1:0]   read_time;
        logic [GRAMS_W-1:0]  read_grams;
    } result_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic               upd;
        logic               shift_all;
        logic [TIME_W-1:0]  new_time;
        logic [GRAMS_W-1:0] new_grams;
        logic [TIME_W-1:0]  match_time;
        logic [GRAMS_W-1:0] match_grams;
    } cell_ctl_t;

endpackage

// ===== rtl/nst_cell.sv =====
// ----------------------------------------------------------------------------
// nst_cell
// One position of the sorted chain: holds a record and a match flag, and
// takes data from its left or right neighbour or from the new record.
// ----------------------------------------------------------------------------
module nst_cell #(
    parameter int IDX = 0,
    parameter int CW  = 9,
    parameter int SW  = 1,
    localparam int PW = 1 << SW
) (
    input  logic                        clk,
    input  nst_pkg::cell_ctl_t          ctl,
    input  logic [SW-1:0]               step,
    input  logic [CW-1:0]               count,
    input  logic [PW-1:0]               pre,
    input  logic                        left_valid,
    input  logic                        left_below,
    input  logic [nst_pkg::TIME_W-1:0]  left_time,
    input  logic [nst_pkg::GRAMS_W-1:0] left_grams,
    input  logic [nst_pkg::TIME_W-1:0]  right_time,
    input  logic [nst_pkg::GRAMS_W-1:0] right_grams,
    output logic                        valid,
    output logic                        below,
    output logic                        seen,
    output logic [nst_pkg::TIME_W-1:0]  entry_time,
    output logic [nst_pkg::GRAMS_W-1:0] entry_grams
);

    import nst_pkg::*;

    localparam logic [CW-1:0] POS = CW'(IDX);

    logic [TIME_W-1:0]  time_reg;
    logic [TIME_W-1:0]  time_next;
    logic [GRAMS_W-1:0] grams_reg;
    logic [GRAMS_W-1:0] grams_next;
    logic               seen_reg;
    logic               seen_next;
    logic               hit;
    logic               in_span;

    assign valid   = POS < count;
    assign in_span = POS <= count;
    // entries on the right of a removed match stay ahead only when strictly older
    assign below   = valid & ((ctl.upd & seen_reg) ? (time_reg < ctl.new_time)
                                                   : (time_reg <= ctl.new_time));
    assign hit     = valid & (time_reg == ctl.match_time) & (grams_reg == ctl.match_grams);

    always_comb
    begin
        time_next  = time_reg;
        grams_next = grams_reg;
        seen_next  = seen_reg;
        case (ctl.cmd)
            CMD_HIT:
            begin
                seen_next = hit;
            end
            CMD_PREFIX:
            begin
                seen_next = seen_reg | pre[step];
            end
            CMD_SHIFT:
            begin
                if (ctl.shift_all || seen_reg)
                begin
                    time_next  = right_time;
                    grams_next = right_grams;
                end
            end
            CMD_INSERT:
            begin
                if (in_span && left_valid && !left_below)
                begin
                    time_next  = left_time;
                    grams_next = left_grams;
                end
                else if (in_span && !below)
                begin
                    time_next  = ctl.new_time;
                    grams_next = ctl.new_grams;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        time_reg  <= time_next;
        grams_reg <= grams_next;
        seen_reg  <= seen_next;
    end

    assign seen        = seen_reg;
    assign entry_time  = time_reg;
    assign entry_grams = grams_reg;

endmodule

// ===== rtl/newest_n_sorted_record_table.sv =====
// ----------------------------------------------------------------------------
// newest_n_sorted_record_table_core
// Keeps the newest DEPTH (time, grams) records sorted oldest first in a
// chain of cells; insert, update, delete and read by index.
// ----------------------------------------------------------------------------
// Usage
//   item / item_valid / item_ready carry one operation; result / result_valid
//   / result_ready return exactly one answer for it, in order.
//   One operation is worked on at a time; item_ready is high only while the
//   sequencer is idle.
//   Each item passes S_CHECK and ends in S_FINISH; an insert below capacity
//   adds S_INSERT, an insert that evicts adds S_SHIFT and S_INSERT, a delete
//   or an accepted update adds S_PREFIX and S_SHIFT, and a matched update
//   adds S_INSERT after them. item_ready rises again as the result is loaded.
//   The match search runs a prefix over the chain's hit flags that doubles
//   its reach each cycle, for updates and deletes.
//   Reads select a cell through a multiplexer over the first 256 cells.
//   Configuration writes (cfg_we, cfg_index, cfg_data) act at once and are
//   meant for idle periods only.
//   Reset empties the table and loads the default limits; cell contents are
//   not cleared.
//   A stalled receiver holds the result in the output register; the block
//   waits with the next one until that register is free.
// ----------------------------------------------------------------------------
module newest_n_sorted_record_table_core #(
    parameter int DEPTH = nst_pkg::NST_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  nst_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output nst_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [nst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nst_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import nst_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int LOG  = $clog2(DEPTH);
    localparam int SW   = (LOG > 1) ? $clog2(LOG) : 1;
    localparam int PW   = 1 << SW;
    localparam int RN   = (DEPTH < 256) ? DEPTH : 256;
    localparam int RIW  = $clog2(RN);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_PREFIX = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [SW-1:0]       step_reg;
    logic [SW-1:0]       step_next;
    logic                shift_all_reg;
    logic                shift_all_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [TIME_W-1:0]   rd_time_reg;
    logic [TIME_W-1:0]   rd_time_next;
    logic [GRAMS_W-1:0]  rd_grams_reg;
    logic [GRAMS_W-1:0]  rd_grams_next;
    item_t               item_reg;
    logic                result_valid_reg;
    logic                result_valid_next;
    result_t             result_reg;
    result_t             result_next;

    logic [GRAMS_W-1:0]  min_grams_reg;
    logic [GRAMS_W-1:0]  max_grams_reg;
    logic [TIME_W-1:0]   time_limit_reg;

    cell_ctl_t           ctl;
    logic [TIME_W-1:0]   cell_time [DEPTH];
    logic [GRAMS_W-1:0]  cell_grams [DEPTH];
    logic [DEPTH-1:0]    cell_valid;
    logic [DEPTH-1:0]    cell_below;
    logic [DEPTH-1:0]    cell_seen;
    logic [TIME_W-1:0]   rd_times [RN];
    logic [GRAMS_W-1:0]  rd_grams [RN];

    logic                values_ok;
    logic                full;
    logic                read_hit;

    assign item_ready   = state_reg == S_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_grams_reg  <= MIN_GRAMS_RESET;
            max_grams_reg  <= MAX_GRAMS_RESET;
            time_limit_reg <= TIME_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_GRAMS:  min_grams_reg  <= cfg_data[GRAMS_W-1:0];
                REG_MAX_GRAMS:  max_grams_reg  <= cfg_data[GRAMS_W-1:0];
                REG_TIME_LIMIT: time_limit_reg <= cfg_data[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign values_ok = (item_reg.new_time != '0) && (item_reg.new_time < time_limit_reg)
                       && (item_reg.new_grams >= min_grams_reg)
                       && (item_reg.new_grams <= max_grams_reg);
    assign full      = count_reg == CW'(DEPTH);
    assign read_hit  = CMPW'(item_reg.read_index) < CMPW'(count_reg);

    always_comb
    begin
        ctl.cmd         = CMD_HOLD;
        ctl.upd         = item_reg.action == ACT_UPDATE;
        ctl.shift_all   = shift_all_reg;
        ctl.new_time    = item_reg.new_time;
        ctl.new_grams   = item_reg.new_grams;
        ctl.match_time  = item_reg.match_time;
        ctl.match_grams = item_reg.match_grams;
        case (state_reg)
            S_CHECK:  ctl.cmd = CMD_HIT;
            S_PREFIX: ctl.cmd = CMD_PREFIX;
            S_SHIFT:
            begin
                if (shift_all_reg || cell_seen[DEPTH-1])
                begin
                    ctl.cmd = CMD_SHIFT;
                end
            end
            S_INSERT: ctl.cmd = CMD_INSERT;
            default:  ctl.cmd = CMD_HOLD;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        step_next         = step_reg;
        shift_all_next    = shift_all_reg;
        status_next       = status_reg;
        rd_time_next      = rd_time_reg;
        rd_grams_next     = rd_grams_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                status_next    = ST_DONE;
                step_next      = '0;
                shift_all_next = 1'b0;
                rd_time_next   = '0;
                rd_grams_next  = '0;
                case (item_reg.action)
                    ACT_INSERT:
                    begin
                        if (!values_ok)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_FINISH;
                        end
                        else if (full && (item_reg.new_time < cell_time[0]))
                        begin
                            status_next = ST_DROPPED;
                            state_next  = S_FINISH;
                        end
                        else if (full)
                        begin
                            shift_all_next = 1'b1;
                            state_next     = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_INSERT;
                        end
                    end
                    ACT_UPDATE:
                    begin
                        if (!values_ok)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_PREFIX;
                        end
                    end
                    ACT_DELETE:
                    begin
                        state_next = S_PREFIX;
                    end
                    default:
                    begin
                        if (read_hit)
                        begin
                            rd_time_next  = rd_times[item_reg.read_index[RIW-1:0]];
                            rd_grams_next = rd_grams[item_reg.read_index[RIW-1:0]];
                        end
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_PREFIX:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(LOG - 1))
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (!shift_all_reg && !cell_seen[DEPTH-1])
                begin
                    status_next = ST_NOMATCH;
                    state_next  = S_FINISH;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (shift_all_reg || (item_reg.action == ACT_UPDATE))
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_INSERT:
            begin
                count_next = count_reg + 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next       = 1'b1;
                    result_next.status      = status_reg;
                    result_next.entry_count = COUNT_W'(count_reg);
                    result_next.read_time   = rd_time_reg;
                    result_next.read_grams  = rd_grams_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        step_reg      <= step_next;
        shift_all_reg <= shift_all_next;
        status_reg    <= status_next;
        rd_time_reg   <= rd_time_next;
        rd_grams_reg  <= rd_grams_next;
        result_reg    <= result_next;
    end

    for (genvar r = 0; r < RN; r++)
    begin : g_rd
        assign rd_times[r] = cell_time[r];
        assign rd_grams[r] = cell_grams[r];
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [PW-1:0]      pre;
        logic               left_valid;
        logic               left_below;
        logic [TIME_W-1:0]  left_time;
        logic [GRAMS_W-1:0] left_grams;
        logic [TIME_W-1:0]  right_time;
        logic [GRAMS_W-1:0] right_grams;

        for (genvar k = 0; k < PW; k++)
        begin : g_pre
            if ((k < LOG) && (i >= (1 << k)))
            begin : g_tap
                assign pre[k] = cell_seen[i - (1 << k)];
            end
            else
            begin : g_zero
                assign pre[k] = 1'b0;
            end
        end

        if (i > 0)
        begin : g_left
            assign left_valid = cell_valid[i-1];
            assign left_below = cell_below[i-1];
            assign left_time  = cell_time[i-1];
            assign left_grams = cell_grams[i-1];
        end
        else
        begin : g_left_end
            assign left_valid = 1'b0;
            assign left_below = 1'b0;
            assign left_time  = '0;
            assign left_grams = '0;
        end

        if (i < DEPTH - 1)
        begin : g_right
            assign right_time  = cell_time[i+1];
            assign right_grams = cell_grams[i+1];
        end
        else
        begin : g_right_end
            assign right_time  = '0;
            assign right_grams = '0;
        end

        nst_cell #(
            .IDX (i),
            .CW  (CW),
            .SW  (SW)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .step        (step_reg),
            .count       (count_reg),
            .pre         (pre),
            .left_valid  (left_valid),
            .left_below  (left_below),
            .left_time   (left_time),
            .left_grams  (left_grams),
            .right_time  (right_time),
            .right_grams (right_grams),
            .valid       (cell_valid[i]),
            .below       (cell_below[i]),
            .seen        (cell_seen[i]),
            .entry_time  (cell_time[i]),
            .entry_grams (cell_grams[i])
        );
    end

endmodule

// ===== rtl/nst_checker.sv =====
// ----------------------------------------------------------------------------
// nst_checker
// Port-level checks of the sorted record table, attached to the top level
// by the bind below.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nst_checker #(
    parameter int DEPTH = nst_pkg::NST_DEPTH
) (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input nst_pkg::item_t     item,
    input logic               result_valid,
    input logic               result_ready,
    input nst_pkg::result_t   result
);

    import nst_pkg::*;

    logic [ACTION_W-1:0] pend_action_reg;
    logic [ACTION_W-1:0] shown_action_reg;
    logic [ACTION_W-1:0] shown_action;
    logic                fresh_reg;
    logic                stalled;
    logic                taken;
    logic                other_shown;
    logic                insert_shown;
    logic                read_clear;
    logic                no_match;

    // action of the transaction in flight and of the result on show
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_action_reg  <= ACT_READ;
            shown_action_reg <= ACT_READ;
            fresh_reg        <= 1'b1;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                pend_action_reg <= item.action;
            end
            shown_action_reg <= shown_action;
            fresh_reg        <= !result_valid || result_ready;
        end
    end

    // a result seen after an empty or accepted output belongs to the pending transaction
    assign shown_action = fresh_reg ? pend_action_reg : shown_action_reg;
    assign stalled      = result_valid && !result_ready;
    assign taken        = item_valid && item_ready;
    assign other_shown  = result_valid && (shown_action != ACT_READ);
    assign insert_shown = result_valid && (shown_action == ACT_INSERT);
    assign read_clear   = (result.read_time == '0) && (result.read_grams == '0);
    assign no_match     = result.status == ST_NOMATCH;

    `NST_ASSERT_NEXT(a_result_hold, stalled, result_valid && $stable(result), "result moved")
    `NST_ASSERT_NEXT(a_ready_drops, taken, !item_ready, "second transaction taken while busy")
    `NST_ASSERT(a_count_bound, result_valid |-> (int'(result.entry_count) <= DEPTH), "count high")
    `NST_ASSERT(a_read_zero, other_shown |-> read_clear, "read fields set on a non-read")
    `NST_ASSERT(a_insert_status, insert_shown |-> !no_match, "insert answered no match")

endmodule

bind newest_n_sorted_record_table_core nst_checker #(.DEPTH(DEPTH)) u_nst_checker (.*);

// ===== dv/tb_newest_n_sorted_record_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_newest_n_sorted_record_table_core
// Self-checking bench for the sorted record table. A scoreboard class keeps
// its own copy of the table and the limits, works out the answer to every
// accepted transaction and compares the answers that come back in order.
// Directed items at the empty table come first, then random traffic under
// several limit settings, including a full table and a long receiver stall.
// ----------------------------------------------------------------------------
module tb_newest_n_sorted_record_table_core;

    import nst_pkg::*;

    class sorted_table_scoreboard;
        logic [TIME_W-1:0]  times [NST_DEPTH];
        logic [GRAMS_W-1:0] grams [NST_DEPTH];
        int                 count;
        logic [GRAMS_W-1:0] lo_grams;
        logic [GRAMS_W-1:0] hi_grams;
        logic [TIME_W-1:0]  limit;
        result_t            awaited[$];
        int                 faults;

        function new();
            count    = 0;
            faults   = 0;
            lo_grams = MIN_GRAMS_RESET;
            hi_grams = MAX_GRAMS_RESET;
            limit    = TIME_LIMIT_RESET;
        endfunction

        function void set_limits(logic [GRAMS_W-1:0] lo, logic [GRAMS_W-1:0] hi,
                                 logic [TIME_W-1:0] lim);
            lo_grams = lo;
            hi_grams = hi;
            limit    = lim;
        endfunction

        function bit values_ok(logic [TIME_W-1:0] t, logic [GRAMS_W-1:0] g);
            return (t != '0) && (t < limit) && (g >= lo_grams) && (g <= hi_grams);
        endfunction

        // stable insertion sort, oldest first
        function void resort();
            logic [TIME_W-1:0]  kt;
            logic [GRAMS_W-1:0] kg;
            int                 j;
            for (int i = 1; i < count; i++)
            begin
                kt = times[i];
                kg = grams[i];
                j  = i;
                while (j > 0 && times[j-1] > kt)
                begin
                    times[j] = times[j-1];
                    grams[j] = grams[j-1];
                    j--;
                end
                times[j] = kt;
                grams[j] = kg;
            end
        endfunction

        function void remove_at(int idx);
            for (int j = idx + 1; j < count; j++)
            begin
                times[j-1] = times[j];
                grams[j-1] = grams[j];
            end
            count--;
        endfunction

        function int find_match(logic [TIME_W-1:0] t, logic [GRAMS_W-1:0] g);
            for (int i = 0; i < count; i++)
                if (times[i] == t && grams[i] == g)
                    return i;
            return count;
        endfunction

        function void note_item(item_t it);
            result_t want;
            int      hit;
            want = '0;
            case (it.action)
                ACT_INSERT:
                begin
                    if (!values_ok(it.new_time, it.new_grams))
                        want.status = ST_RANGE;
                    else if (count == NST_DEPTH && it.new_time < times[0])
                        want.status = ST_DROPPED;
                    else
                    begin
                        if (count == NST_DEPTH)
                            remove_at(0);
                        times[count] = it.new_time;
                        grams[count] = it.new_grams;
                        count++;
                        resort();
                        want.status = ST_DONE;
                    end
                end
                ACT_UPDATE:
                begin
                    if (!values_ok(it.new_time, it.new_grams))
                        want.status = ST_RANGE;
                    else
                    begin
                        hit = find_match(it.match_time, it.match_grams);
                        if (hit >= count)
                            want.status = ST_NOMATCH;
                        else
                        begin
                            times[hit] = it.new_time;
                            grams[hit] = it.new_grams;
                            resort();
                            want.status = ST_DONE;
                        end
                    end
                end
                ACT_DELETE:
                begin
                    hit = find_match(it.match_time, it.match_grams);
                    if (hit >= count)
                        want.status = ST_NOMATCH;
                    else
                    begin
                        remove_at(hit);
                        want.status = ST_DONE;
                    end
                end
                default:
                begin
                    want.status = ST_DONE;
                    if (int'(it.read_index) < count)
                    begin
                        want.read_time  = times[it.read_index];
                        want.read_grams = grams[it.read_index];
                    end
                end
            endcase
            want.entry_count = COUNT_W'(count);
            awaited.push_back(want);
        endfunction

        function void check_answer(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("answer with nothing awaited: status %0d count %0d",
                             got.status, got.entry_count);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.entry_count !== want.entry_count ||
                got.read_time !== want.read_time || got.read_grams !== want.read_grams)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $write("mismatch: status %0d/%0d count %0d/%0d ",
                           want.status, got.status, want.entry_count, got.entry_count);
                    $display("time %0h/%0h grams %0h/%0h (expected/actual)",
                             want.read_time, got.read_time, want.read_grams, got.read_grams);
                end
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    sorted_table_scoreboard sb = new();
    int send_calm = 0;
    int take_calm = 0;

    newest_n_sorted_record_table_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // random gap with occasional runs of back-to-back transactions
    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic item_t mk(logic [ACTION_W-1:0] act, logic [TIME_W-1:0] nt,
                                 logic [GRAMS_W-1:0] ng, logic [TIME_W-1:0] mt,
                                 logic [GRAMS_W-1:0] mg, logic [INDEX_W-1:0] ri);
        item_t it;
        it.action      = act;
        it.new_time    = nt;
        it.new_grams   = ng;
        it.match_time  = mt;
        it.match_grams = mg;
        it.read_index  = ri;
        return it;
    endfunction

    function automatic logic [TIME_W-1:0] wide_time();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] pick_time(int noise);
        if ($urandom_range(0, 99) >= noise)
            return TIME_W'($urandom_range(1, 400));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return sb.limit;
            2:       return sb.limit - 1;
            default: return wide_time();
        endcase
    endfunction

    function automatic logic [GRAMS_W-1:0] pick_grams(int noise);
        if ($urandom_range(0, 99) >= noise && sb.lo_grams <= sb.hi_grams)
            return GRAMS_W'($urandom_range(sb.lo_grams, sb.hi_grams));
        case ($urandom_range(0, 4))
            0:       return sb.lo_grams;
            1:       return sb.hi_grams;
            2:       return sb.lo_grams - 1;
            3:       return sb.hi_grams + 1;
            default: return GRAMS_W'($urandom);
        endcase
    endfunction

    function automatic item_t random_item(int insert_w, int noise);
        item_t it;
        int    k;
        int    roll;
        it = mk(ACT_READ, wide_time(), GRAMS_W'($urandom), wide_time(),
                GRAMS_W'($urandom), INDEX_W'($urandom));
        if ($urandom_range(0, 99) < insert_w)
            it.action = ACT_INSERT;
        else
            case ($urandom_range(0, 2))
                0:       it.action = ACT_UPDATE;
                1:       it.action = ACT_DELETE;
                default: it.action = ACT_READ;
            endcase
        if (it.action != ACT_READ)
        begin
            it.new_time  = pick_time(noise);
            it.new_grams = pick_grams(noise);
        end
        // full table: aim at the oldest entry, tied or just older
        if (it.action == ACT_INSERT && sb.count == NST_DEPTH)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 3)
                it.new_time = sb.times[0];
            else if (roll < 6)
                it.new_time = sb.times[0] - 1;
        end
        if ((it.action == ACT_UPDATE || it.action == ACT_DELETE) && sb.count > 0)
        begin
            roll = $urandom_range(0, 9);
            k    = $urandom_range(0, sb.count - 1);
            if (roll < 8)
            begin
                it.match_time  = sb.times[k];
                it.match_grams = sb.grams[k];
            end
            else if (roll < 9)
            begin
                it.match_time  = sb.times[k];
                it.match_grams = sb.grams[k] + 1;
            end
        end
        if (it.action == ACT_READ && $urandom_range(0, 9) < 7)
            it.read_index = INDEX_W'($urandom_range(0, (sb.count > 255) ? 255 : sb.count));
        return it;
    endfunction

    task automatic send_item(item_t it);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        sb.note_item(it);
    endtask

    task automatic run_mix(int n, int insert_w, int noise);
        for (int k = 0; k < n; k++)
            send_item(random_item(insert_w, noise));
    endtask

    // wait for every outstanding answer, then let the block go quiet
    task automatic settle();
        item_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic apply_limits(logic [GRAMS_W-1:0] lo, logic [GRAMS_W-1:0] hi,
                                logic [TIME_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_GRAMS;
        cfg_data  <= CFG_DATA_W'(lo);
        @(posedge clk);
        cfg_index <= REG_MAX_GRAMS;
        cfg_data  <= CFG_DATA_W'(hi);
        @(posedge clk);
        cfg_index <= REG_TIME_LIMIT;
        cfg_data  <= CFG_DATA_W'(lim);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_limits(lo, hi, lim);
    endtask

    initial
    begin : answer_sink
        int gap;
        int taken;
        bit held;
        taken = 0;
        held  = 0;
        forever
        begin
            gap = draw_gap(take_calm);
            // one long stall so a held result stalls the block and blocks its input
            if (!held && taken == 150)
            begin
                gap  = 400;
                held = 1;
            end
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (result_valid !== 1'b1);
            sb.check_answer(result);
            taken++;
        end
    end

    initial
    begin : stimulus
        int extra;
        extra = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apply_limits(MIN_GRAMS_RESET, MAX_GRAMS_RESET, TIME_LIMIT_RESET);

        // empty table corner cases
        send_item(mk(ACT_READ, 0, 0, 0, 0, 0));
        send_item(mk(ACT_DELETE, 0, 0, 100, 30000, 0));
        send_item(mk(ACT_UPDATE, 100, 30000, 100, 30000, 0));
        send_item(mk(ACT_UPDATE, 0, 30000, 5, 5, 0));
        send_item(mk(ACT_INSERT, 0, 30000, 0, 0, 0));
        send_item(mk(ACT_INSERT, TIME_LIMIT_RESET, 30000, 0, 0, 0));
        send_item(mk(ACT_INSERT, TIME_LIMIT_RESET - 1, MAX_GRAMS_RESET, 0, 0, 0));
        send_item(mk(ACT_INSERT, 1, MIN_GRAMS_RESET, 0, 0, 0));
        send_item(mk(ACT_INSERT, 200, MIN_GRAMS_RESET - 1, 0, 0, 0));
        send_item(mk(ACT_INSERT, 200, MAX_GRAMS_RESET + 1, 0, 0, 0));
        // equal times keep arrival order
        send_item(mk(ACT_INSERT, 100, 30000, 0, 0, 0));
        send_item(mk(ACT_INSERT, 100, 40000, 0, 0, 0));
        send_item(mk(ACT_INSERT, 100, 30000, 0, 0, 0));
        send_item(mk(ACT_READ, 0, 0, 0, 0, 1));
        send_item(mk(ACT_READ, 0, 0, 0, 0, 2));
        send_item(mk(ACT_READ, 0, 0, 0, 0, 3));
        send_item(mk(ACT_READ, '1, '1, '1, '1, '1));
        send_item(mk(ACT_UPDATE, 50, 60000, 100, 30000, 0));
        send_item(mk(ACT_UPDATE, 100, 70000, 100, 30000, 0));
        send_item(mk(ACT_DELETE, 0, 0, 100, 40000, 0));
        send_item(mk(ACT_DELETE, 0, 0, 100, 12345, 0));
        // bad values win over a missing match
        send_item(mk(ACT_UPDATE, 10, MAX_GRAMS_RESET + 1, 7, 7, 0));
        send_item(mk(ACT_INSERT, '1, '1, '1, '1, '1));
        send_item(mk(ACT_READ, 0, 0, 0, 0, 0));
        settle();

        run_mix(70, 50, 20);
        settle();

        // widest limits, fill the table and keep it full for a while
        apply_limits('0, '1, '1);
        for (int k = 0; k < 700 && extra < 40; k++)
        begin
            send_item(random_item(95, 4));
            if (sb.count == NST_DEPTH)
                extra++;
        end
        settle();

        apply_limits(MIN_GRAMS_RESET, MAX_GRAMS_RESET, TIME_LIMIT_RESET);
        run_mix(90, 40, 15);
        settle();

        // empty ranges: every insert and update is rejected
        apply_limits('1, '0, '0);
        run_mix(15, 50, 20);
        settle();
        apply_limits('0, '1, 1);
        run_mix(10, 50, 10);
        settle();

        // single weight window
        apply_limits(30000, 30000, '1);
        run_mix(30, 40, 20);
        settle();

        apply_limits(MIN_GRAMS_RESET, MAX_GRAMS_RESET, TIME_LIMIT_RESET);
        run_mix(30, 30, 20);
        settle();

        if (sb.faults == 0 && sb.awaited.size() == 0)
            $display("newest_n_sorted_record_table_core regression: pass");
        else
            $display("newest_n_sorted_record_table_core regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #1000000;
        $display("newest_n_sorted_record_table_core regression: fail");
        $finish;
    end

endmodule
